### design/double_ended_priority_queue_unit_assert.svh
// Assertion macros shared by the priority queue RTL.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DEPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DEPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/depq_pkg.sv
// Types and constants shared by the priority queue modules.
package depq_pkg;

    localparam int DEPQ_CAPACITY = 1024;
    localparam int DEPQ_DATA_W   = 32;
    localparam int DEPQ_OCC_W    = 11;

    localparam logic [1:0] ACT_INSERT     = 2'd0;
    localparam logic [1:0] ACT_REMOVE_MIN = 2'd1;
    localparam logic [1:0] ACT_REMOVE_MAX = 2'd2;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic                          ins;   // sorted insert of val
        logic                          rmin;  // whole chain moves one place down
        logic signed [DEPQ_DATA_W-1:0] val;
    } depq_cmd_t;

endpackage

### design/depq_cell.sv
// One cell of the sorted chain: holds one value and trades with its neighbours.
module depq_cell
    import depq_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CW    = 11
) (
    input  logic                          aclk,
    input  depq_cmd_t                     cmd,
    input  logic [CW-1:0]                 count,
    input  logic signed [DEPQ_DATA_W-1:0] left_val,
    input  logic                          left_ge,
    input  logic signed [DEPQ_DATA_W-1:0] right_val,
    output logic signed [DEPQ_DATA_W-1:0] val,
    output logic                          ge,
    output logic signed [DEPQ_DATA_W-1:0] leaf
);

    logic signed [DEPQ_DATA_W-1:0] val_reg;
    logic signed [DEPQ_DATA_W-1:0] val_next;
    logic                          occupied;
    logic                          is_last;

    assign occupied = count > CW'(INDEX);
    assign is_last  = count == CW'(INDEX + 1);

    // Empty cells count as greater, so a value above every entry lands at the first free cell.
    assign ge   = !occupied || (val_reg > cmd.val);
    assign val  = val_reg;
    assign leaf = is_last ? val_reg : '0;

    always_comb begin
        val_next = val_reg;
        if (cmd.ins) begin
            if (left_ge) begin
                val_next = left_val;
            end else if (ge) begin
                val_next = cmd.val;
            end
        end else if (cmd.rmin) begin
            val_next = right_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

### design/depq_max_tree.sv
// Registered OR tree that picks out the one non-zero leaf (the largest entry).
module depq_max_tree
    import depq_pkg::*;
#(
    parameter int N = DEPQ_CAPACITY
) (
    input  logic                          aclk,
    input  logic signed [DEPQ_DATA_W-1:0] leaf [N],
    output logic signed [DEPQ_DATA_W-1:0] root
);

    localparam int LEVELS = $clog2(N);
    localparam int P      = 1 << LEVELS;

    logic signed [DEPQ_DATA_W-1:0] leaf_pad [P];
    logic signed [DEPQ_DATA_W-1:0] node_reg [1:P-1];

    genvar g;
    generate
        for (g = 0; g < P; g++) begin : g_pad
            if (g < N) begin : g_leaf
                assign leaf_pad[g] = leaf[g];
            end else begin : g_zero
                assign leaf_pad[g] = '0;
            end
        end

        for (g = 1; g < P; g++) begin : g_node
            if (2 * g >= P) begin : g_bottom
                always_ff @(posedge aclk) begin
                    node_reg[g] <= leaf_pad[2*g-P] | leaf_pad[2*g+1-P];
                end
            end else begin : g_inner
                always_ff @(posedge aclk) begin
                    node_reg[g] <= node_reg[2*g] | node_reg[2*g+1];
                end
            end
        end
    endgenerate

    assign root = node_reg[1];

endmodule

### design/double_ended_priority_queue_unit.sv
// Double-ended priority queue: a sorted chain of cells with minimum and maximum readout.
//
// Values sit in a chain of CAPACITY cells in ascending signed order, the minimum
// always in the first cell. An insert is placed by every cell comparing itself
// with the new value and shifting up where needed; a minimum removal moves
// the whole chain down one place; a maximum removal only lowers the count. The
// largest entry is found by a registered OR tree of $clog2(CAPACITY) levels over the
// cells, and that tree sets the pace: a new request is accepted only once the tree has
// settled and the last result is loaded. The result waits in an output register;
// the next request is still accepted, but its result is loaded only after that one is taken.
// Removals on an empty store return removed_valid = 0; inserts into a full store
// are dropped with insert_dropped = 1; action code 3 changes nothing.
`include "double_ended_priority_queue_unit_assert.svh"

module double_ended_priority_queue_unit
    import depq_pkg::*;
#(
    parameter int CAPACITY = DEPQ_CAPACITY
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] value
    input  logic [1:0]   s_tuser,   // [1:0] action
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] removed_value, [63:32] current_min, [95:64] current_max,
    // [106:96] occupancy, [107] is_empty, [111:108] zero
    output logic [111:0] m_tdata,
    output logic [1:0]   m_tuser    // [0] removed_valid, [1] insert_dropped
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int LEVELS = $clog2(CAPACITY);
    localparam int WCW    = $clog2(LEVELS + 1);

    typedef enum logic {
        S_IDLE,
        S_WAIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [WCW-1:0]                wait_reg, wait_next;
    logic signed [DEPQ_DATA_W-1:0] removed_reg, removed_next;
    logic                          rvalid_reg, rvalid_next;
    logic                          dropped_reg, dropped_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [111:0]                  m_tdata_reg, m_tdata_next;
    logic [1:0]                    m_tuser_reg, m_tuser_next;

    depq_cmd_t                     cmd;
    logic                          accept;
    logic                          full;
    logic                          empty;
    logic                          load;
    logic [CW+DEPQ_OCC_W-1:0]      occ_wide;
    logic signed [DEPQ_DATA_W-1:0] cur_min;
    logic signed [DEPQ_DATA_W-1:0] tree_max;

    logic signed [DEPQ_DATA_W-1:0] cell_val  [CAPACITY];
    logic                          cell_ge   [CAPACITY];
    logic signed [DEPQ_DATA_W-1:0] cell_leaf [CAPACITY];

    assign s_tready = state_reg == S_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign full     = count_reg == CW'(CAPACITY);
    assign empty    = count_reg == '0;

    assign cmd.ins  = accept && (s_tuser == ACT_INSERT) && !full;
    assign cmd.rmin = accept && (s_tuser == ACT_REMOVE_MIN) && !empty;
    assign cmd.val  = $signed(s_tdata);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [DEPQ_DATA_W-1:0] lv;
            logic                          lg;
            logic signed [DEPQ_DATA_W-1:0] rv;
            if (g == 0) begin : g_first
                assign lv = '0;
                assign lg = 1'b0;
            end else begin : g_mid
                assign lv = cell_val[g-1];
                assign lg = cell_ge[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign rv = '0;
            end else begin : g_body
                assign rv = cell_val[g+1];
            end
            depq_cell #(
                .INDEX (g),
                .CW    (CW)
            ) u_cell (
                .aclk      (aclk),
                .cmd       (cmd),
                .count     (count_reg),
                .left_val  (lv),
                .left_ge   (lg),
                .right_val (rv),
                .val       (cell_val[g]),
                .ge        (cell_ge[g]),
                .leaf      (cell_leaf[g])
            );
        end
    endgenerate

    depq_max_tree #(
        .N (CAPACITY)
    ) u_max_tree (
        .aclk (aclk),
        .leaf (cell_leaf),
        .root (tree_max)
    );

    assign cur_min  = empty ? '0 : cell_val[0];
    assign occ_wide = {{DEPQ_OCC_W{1'b0}}, count_reg};
    assign load     = (state_reg == S_WAIT) && (wait_reg == '0)
                      && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        wait_next     = wait_reg;
        removed_next  = removed_reg;
        rvalid_next   = rvalid_reg;
        dropped_next  = dropped_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next   = S_WAIT;
                    wait_next    = WCW'(LEVELS);
                    removed_next = '0;
                    rvalid_next  = 1'b0;
                    dropped_next = 1'b0;
                    case (s_tuser)
                        ACT_INSERT: begin
                            if (full) begin
                                dropped_next = 1'b1;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_REMOVE_MIN: begin
                            if (!empty) begin
                                removed_next = cell_val[0];
                                rvalid_next  = 1'b1;
                                count_next   = count_reg - 1'b1;
                            end
                        end
                        ACT_REMOVE_MAX: begin
                            // tree has settled on the current state while idle
                            if (!empty) begin
                                removed_next = tree_max;
                                rvalid_next  = 1'b1;
                                count_next   = count_reg - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WAIT: begin
                if (wait_reg != '0) begin
                    wait_next = wait_reg - 1'b1;
                end else if (load) begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, empty, occ_wide[DEPQ_OCC_W-1:0],
                                     tree_max, cur_min, removed_reg};
                    m_tuser_next  = {dropped_reg, rvalid_reg};
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            wait_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            wait_reg     <= wait_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        removed_reg <= removed_next;
        rvalid_reg  <= rvalid_next;
        dropped_reg <= dropped_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `DEPQ_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(CAPACITY), "count above capacity")
    `DEPQ_ASSERT_NXT(a_insert_count, aclk, aresetn, cmd.ins, count_reg == $past(count_reg) + 1'b1, "insert did not bump count")
    `DEPQ_ASSERT_NXT(a_drop_full, aclk, aresetn, accept && (s_tuser == ACT_INSERT) && full, dropped_reg && (count_reg == $past(count_reg)), "full insert not dropped")
    `DEPQ_ASSERT_NXT(a_load_out, aclk, aresetn, load, m_tvalid && (state_reg == S_IDLE), "settled result not presented")
    `DEPQ_ASSERT_IMP(a_empty_flag, aclk, aresetn, m_tvalid, m_tdata[107] == (m_tdata[106:96] == 11'd0), "empty flag disagrees with occupancy")

endmodule
